/* rtl/core/tlik_pkg.sv */
// Shared types, constants and CORDIC helpers for the two-link leg inverse kinematics unit.
package tlik_pkg;

    localparam int CORDIC_ITERATIONS_DEFAULT = 20;
    localparam int CORDIC_ITERATIONS_MAX     = 32;
    localparam int SQ1_STEPS                 = 24;  // root bits of the reach
    localparam int DIV_STEPS                 = 30;  // quotient bits of a cosine
    localparam int SQ2_STEPS                 = 31;  // root bits of the sine

    localparam logic [22:0] LEN_RESET = 23'd65536;

    // Register indexes on the configuration port
    localparam logic REG_UPPER = 1'b0;
    localparam logic REG_LOWER = 1'b1;

    localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [35:0] Q20_ROUND   = 36'sd512;

    typedef struct packed {
        logic signed [23:0] target_x;
        logic signed [23:0] target_z;
    } tlik_in_t;

    typedef struct packed {
        logic signed [23:0] hip_angle;
        logic signed [23:0] knee_angle;
        logic               unreachable;
    } tlik_out_t;

    // Squares and link products
    typedef struct packed {
        logic [46:0]        xx;
        logic [46:0]        zz;
        logic [45:0]        l1sq;
        logic [45:0]        l2sq;
        logic [45:0]        l1l2;
        logic signed [31:0] dy;
        logic signed [31:0] dx;
    } mul_t;

    typedef struct packed {
        logic [47:0]        s;
        logic [45:0]        l1sq;
        logic [45:0]        l2sq;
        logic [45:0]        l1l2;
        logic signed [31:0] dy;
        logic signed [31:0] dx;
    } sum_t;

    // Reach square root, one root bit per stage
    typedef struct packed {
        logic [47:0]        rad;
        logic [25:0]        rem;
        logic [23:0]        root;
        logic signed [49:0] num1;
        logic signed [49:0] num2;
        logic [48:0]        den2;
        logic signed [31:0] dy;
        logic signed [31:0] dx;
    } sq1_t;

    typedef struct packed {
        logic signed [49:0] num1;
        logic signed [49:0] num2;
        logic [48:0]        den1;
        logic [48:0]        den2;
        logic signed [31:0] dy;
        logic signed [31:0] dx;
        logic               lenzero;
    } pre_t;

    // One restoring divider lane
    typedef struct packed {
        logic [49:0] r;
        logic [29:0] q;
        logic [48:0] d;
        logic        neg;
        logic        sat;
    } lane_t;

    typedef struct packed {
        lane_t [1:0]        ln;
        logic signed [31:0] dy;
        logic signed [31:0] dx;
        logic               flag;
    } dv_t;

    typedef struct packed {
        logic [1:0][31:0]   c;
        logic [1:0][30:0]   cmag;
        logic signed [31:0] dy;
        logic signed [31:0] dx;
        logic               flag;
    } cs_t;

    typedef struct packed {
        logic [1:0][60:0]   csq;
        logic [1:0][31:0]   c;
        logic signed [31:0] dy;
        logic signed [31:0] dx;
        logic               flag;
    } cq_t;

    // Sine square root, both lanes
    typedef struct packed {
        logic [1:0][61:0]   rad;
        logic [1:0][32:0]   rem;
        logic [1:0][30:0]   root;
        logic [1:0][31:0]   c;
        logic signed [31:0] dy;
        logic signed [31:0] dx;
        logic               flag;
    } sq2_t;

    // One vectoring CORDIC lane
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               zero;
    } cl_t;

    typedef struct packed {
        cl_t [2:0] ln;
        logic      flag;
    } cor_t;

    function automatic logic signed [33:0] atan_entry(input logic [4:0] idx);
        logic signed [33:0] v;
        unique case (idx)
            5'd0:  v = 34'sh03243F6A8;
            5'd1:  v = 34'sh01DAC6705;
            5'd2:  v = 34'sh00FADBAFC;
            5'd3:  v = 34'sh007F56EA6;
            5'd4:  v = 34'sh003FEAB76;
            5'd5:  v = 34'sh001FFD55B;
            5'd6:  v = 34'sh000FFFAAA;
            5'd7:  v = 34'sh0007FFF55;
            5'd8:  v = 34'sh0003FFFEA;
            5'd9:  v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF;
            5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF;
            5'd23: v = 34'sh00000007F;
            5'd24: v = 34'sh00000003F;
            5'd25: v = 34'sh00000001F;
            5'd26: v = 34'sh00000000F;
            5'd27: v = 34'sh000000008;
            5'd28: v = 34'sh000000004;
            5'd29: v = 34'sh000000002;
            5'd30: v = 34'sh000000001;
            5'd31: v = 34'sh000000000;
        endcase
        return v;
    endfunction

    // Fold the left half plane onto the right one
    function automatic cl_t cordic_pre(input logic signed [33:0] y, input logic signed [33:0] x);
        cl_t o;
        o.zero = (x == 34'sd0) && (y == 34'sd0);
        o.x    = x;
        o.y    = y;
        o.z    = 34'sd0;
        if (x < 34'sd0) begin
            if (y >= 34'sd0) begin
                o.x = y;
                o.y = -x;
                o.z = Q30_HALF_PI;
            end else begin
                o.x = -y;
                o.y = x;
                o.z = -Q30_HALF_PI;
            end
        end
        return o;
    endfunction

    // One micro-rotation toward y = 0
    function automatic cl_t cordic_step(input cl_t a, input logic [4:0] k);
        cl_t o;
        logic signed [33:0] dxs;
        logic signed [33:0] dys;
        dxs    = a.y >>> k;
        dys    = a.x >>> k;
        o.zero = a.zero;
        if (a.y >= 34'sd0) begin
            o.x = a.x + dxs;
            o.y = a.y - dys;
            o.z = a.z + atan_entry(k);
        end else begin
            o.x = a.x - dxs;
            o.y = a.y + dys;
            o.z = a.z - atan_entry(k);
        end
        return o;
    endfunction

endpackage

/* rtl/core/two_link_leg_inverse_kinematics_unit.sv */
// Pipelined two-link leg inverse kinematics: foot target in, hip and knee angles out.
//
// Input channel s_*: one foot target (x, z), signed Q8.16, per transfer.
// Output channel m_*: hip and knee angles, signed Q3.20 radians, plus a flag
// that is set when a target is out of reach or a denominator is zero.
// Link lengths are written through the APB port (thigh at 0x0, shank at 0x4);
// the user must write them while no transfer is in flight, which the block
// itself does not enforce; pready is always high. A new target is taken every
// cycle while no result is stalled. The depth is set by the bit-serial pipelines:
// 24 stages for the reach root, 30 for the two cosine dividers, 31 for the
// sine roots and one stage per CORDIC micro-rotation.
// A synchronous low aresetn empties the pipeline and loads both link lengths
// with 1.0. When the receiver stalls with a result waiting, the whole pipeline
// holds; bubbles do not compress, so s_ready follows m_ready while m_valid
// is high and no data is dropped or repeated.
module two_link_leg_inverse_kinematics_unit #(
    parameter int CORDIC_ITERATIONS = tlik_pkg::CORDIC_ITERATIONS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tlik_pkg::tlik_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tlik_pkg::tlik_out_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tlik_pkg::*;

    localparam int DEPTH = 96 + CORDIC_ITERATIONS;

    logic        adv;
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic [22:0] upper_len_reg, upper_len_next;
    logic [22:0] lower_len_reg, lower_len_next;

    tlik_in_t  in_reg, in_next;
    mul_t      mul_reg, mul_next;
    sum_t      sum_reg, sum_next;
    sq1_t      sq1_reg [0:SQ1_STEPS];
    sq1_t      sq1_next [0:SQ1_STEPS];
    pre_t      pre_reg, pre_next;
    dv_t       dv_reg [0:DIV_STEPS];
    dv_t       dv_next [0:DIV_STEPS];
    cs_t       cs_reg, cs_next;
    cq_t       cq_reg, cq_next;
    sq2_t      sq2_reg [0:SQ2_STEPS];
    sq2_t      sq2_next [0:SQ2_STEPS];
    cor_t      cor_reg [0:CORDIC_ITERATIONS];
    cor_t      cor_next [0:CORDIC_ITERATIONS];
    tlik_out_t out_reg, out_next;

    logic signed [47:0] xsq_w, zsq_w;
    logic [45:0] l1sq_w, l2sq_w, l1l2_w;
    logic [46:0] lenl1_w;
    logic [61:0] csq0_w, csq1_w;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LOWER) ? {9'd0, lower_len_reg} : {9'd0, upper_len_reg};

    always_comb begin
        upper_len_next = upper_len_reg;
        lower_len_next = lower_len_reg;
        if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_UPPER: upper_len_next = pwdata[22:0];
                REG_LOWER: lower_len_next = pwdata[22:0];
            endcase
        end
    end

    // Global advance: the pipeline moves unless a finished result is stalled
    assign adv     = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[DEPTH-1];
    assign m_data  = out_reg;
    assign vld_next = {vld_reg[DEPTH-2:0], s_valid};

    // Capture the target
    assign in_next = s_data;

    // Square the target and the link lengths
    assign xsq_w  = in_reg.target_x * in_reg.target_x;
    assign zsq_w  = in_reg.target_z * in_reg.target_z;
    assign l1sq_w = upper_len_reg * upper_len_reg;
    assign l2sq_w = lower_len_reg * lower_len_reg;
    assign l1l2_w = upper_len_reg * lower_len_reg;

    always_comb begin
        mul_next.xx   = xsq_w[46:0];
        mul_next.zz   = zsq_w[46:0];
        mul_next.l1sq = l1sq_w;
        mul_next.l2sq = l2sq_w;
        mul_next.l1l2 = l1l2_w;
        mul_next.dy   = {in_reg.target_x[23], in_reg.target_x, 7'd0};
        mul_next.dx   = 32'sd0 - $signed({in_reg.target_z[23], in_reg.target_z, 7'd0});
    end

    // Sum to the squared reach
    always_comb begin
        sum_next.s    = {1'b0, mul_reg.xx} + {1'b0, mul_reg.zz};
        sum_next.l1sq = mul_reg.l1sq;
        sum_next.l2sq = mul_reg.l2sq;
        sum_next.l1l2 = mul_reg.l1l2;
        sum_next.dy   = mul_reg.dy;
        sum_next.dx   = mul_reg.dx;
    end

    // Numerators, shank denominator, and the reach root one bit per stage
    always_comb begin
        logic [27:0] cand;
        logic [27:0] trial;
        sq1_next[0].rad  = sum_reg.s;
        sq1_next[0].rem  = 26'd0;
        sq1_next[0].root = 24'd0;
        sq1_next[0].num1 = $signed({2'b0, sum_reg.s}) + $signed({4'b0, sum_reg.l1sq})
                           - $signed({4'b0, sum_reg.l2sq});
        sq1_next[0].num2 = $signed({4'b0, sum_reg.l1sq}) + $signed({4'b0, sum_reg.l2sq})
                           - $signed({2'b0, sum_reg.s});
        sq1_next[0].den2 = {2'b0, sum_reg.l1l2, 1'b0};
        sq1_next[0].dy   = sum_reg.dy;
        sq1_next[0].dx   = sum_reg.dx;
        for (int k = 0; k < SQ1_STEPS; k++) begin
            sq1_next[k+1] = sq1_reg[k];
            cand  = {sq1_reg[k].rem, sq1_reg[k].rad[47-2*k -: 2]};
            trial = {2'b0, sq1_reg[k].root, 2'b01};
            if (cand >= trial) begin
                sq1_next[k+1].rem  = 26'(cand - trial);
                sq1_next[k+1].root = {sq1_reg[k].root[22:0], 1'b1};
            end else begin
                sq1_next[k+1].rem  = cand[25:0];
                sq1_next[k+1].root = {sq1_reg[k].root[22:0], 1'b0};
            end
        end
    end

    // Hip-side denominator 2 * L * l1
    assign lenl1_w = sq1_reg[SQ1_STEPS].root * upper_len_reg;

    always_comb begin
        pre_next.num1    = sq1_reg[SQ1_STEPS].num1;
        pre_next.num2    = sq1_reg[SQ1_STEPS].num2;
        pre_next.den1    = {1'b0, lenl1_w, 1'b0};
        pre_next.den2    = sq1_reg[SQ1_STEPS].den2;
        pre_next.dy      = sq1_reg[SQ1_STEPS].dy;
        pre_next.dx      = sq1_reg[SQ1_STEPS].dx;
        pre_next.lenzero = (sq1_reg[SQ1_STEPS].root == 24'd0);
    end

    // Clamp check, then restoring division one quotient bit per stage
    always_comb begin
        logic signed [49:0] num;
        logic [48:0]        den;
        logic [49:0]        mag;
        logic [49:0]        r2;
        logic [1:0]         fl;
        for (int j = 0; j < 2; j++) begin
            num = (j == 0) ? pre_reg.num1 : pre_reg.num2;
            den = (j == 0) ? pre_reg.den1 : pre_reg.den2;
            mag = num[49] ? 50'(-num) : 50'(num);
            fl[j]               = (den == 49'd0) || (mag > {1'b0, den});
            dv_next[0].ln[j].sat = (den == 49'd0) || (mag >= {1'b0, den});
            dv_next[0].ln[j].neg = num[49];
            dv_next[0].ln[j].r   = mag;
            dv_next[0].ln[j].q   = 30'd0;
            dv_next[0].ln[j].d   = den;
        end
        dv_next[0].dy   = pre_reg.dy;
        dv_next[0].dx   = pre_reg.dx;
        dv_next[0].flag = pre_reg.lenzero || fl[0] || fl[1];
        for (int k = 0; k < DIV_STEPS; k++) begin
            dv_next[k+1] = dv_reg[k];
            for (int j = 0; j < 2; j++) begin
                r2 = {dv_reg[k].ln[j].r[48:0], 1'b0};
                if (r2 >= {1'b0, dv_reg[k].ln[j].d}) begin
                    dv_next[k+1].ln[j].r = r2 - {1'b0, dv_reg[k].ln[j].d};
                    dv_next[k+1].ln[j].q = {dv_reg[k].ln[j].q[28:0], 1'b1};
                end else begin
                    dv_next[k+1].ln[j].r = r2;
                    dv_next[k+1].ln[j].q = {dv_reg[k].ln[j].q[28:0], 1'b0};
                end
            end
        end
    end

    // Form the signed cosines
    always_comb begin
        logic [31:0] qx;
        for (int j = 0; j < 2; j++) begin
            qx = {2'b0, dv_reg[DIV_STEPS].ln[j].q};
            if (dv_reg[DIV_STEPS].ln[j].sat) begin
                cs_next.c[j]    = dv_reg[DIV_STEPS].ln[j].neg ? 32'(-Q30_ONE) : 32'(Q30_ONE);
                cs_next.cmag[j] = 31'h4000_0000;
            end else begin
                cs_next.c[j]    = dv_reg[DIV_STEPS].ln[j].neg ? 32'(-qx) : qx;
                cs_next.cmag[j] = {1'b0, dv_reg[DIV_STEPS].ln[j].q};
            end
        end
        cs_next.dy   = dv_reg[DIV_STEPS].dy;
        cs_next.dx   = dv_reg[DIV_STEPS].dx;
        cs_next.flag = dv_reg[DIV_STEPS].flag;
    end

    // Square the cosines
    assign csq0_w = cs_reg.cmag[0] * cs_reg.cmag[0];
    assign csq1_w = cs_reg.cmag[1] * cs_reg.cmag[1];

    always_comb begin
        cq_next.csq[0] = csq0_w[60:0];
        cq_next.csq[1] = csq1_w[60:0];
        cq_next.c      = cs_reg.c;
        cq_next.dy     = cs_reg.dy;
        cq_next.dx     = cs_reg.dx;
        cq_next.flag   = cs_reg.flag;
    end

    // Sines by root of 1 - c^2, one root bit per stage
    always_comb begin
        logic [34:0] cand;
        logic [34:0] trial;
        for (int j = 0; j < 2; j++) begin
            sq2_next[0].rad[j]  = 62'h1000_0000_0000_0000 - {1'b0, cq_reg.csq[j]};
            sq2_next[0].rem[j]  = 33'd0;
            sq2_next[0].root[j] = 31'd0;
        end
        sq2_next[0].c    = cq_reg.c;
        sq2_next[0].dy   = cq_reg.dy;
        sq2_next[0].dx   = cq_reg.dx;
        sq2_next[0].flag = cq_reg.flag;
        for (int k = 0; k < SQ2_STEPS; k++) begin
            sq2_next[k+1] = sq2_reg[k];
            for (int j = 0; j < 2; j++) begin
                cand  = {sq2_reg[k].rem[j], sq2_reg[k].rad[j][61-2*k -: 2]};
                trial = {2'b0, sq2_reg[k].root[j], 2'b01};
                if (cand >= trial) begin
                    sq2_next[k+1].rem[j]  = 33'(cand - trial);
                    sq2_next[k+1].root[j] = {sq2_reg[k].root[j][29:0], 1'b1};
                end else begin
                    sq2_next[k+1].rem[j]  = cand[32:0];
                    sq2_next[k+1].root[j] = {sq2_reg[k].root[j][29:0], 1'b0};
                end
            end
        end
    end

    // Three CORDIC lanes: leg direction, hip offset, knee opening
    always_comb begin
        cor_next[0].ln[0] = cordic_pre(34'(sq2_reg[SQ2_STEPS].dy), 34'(sq2_reg[SQ2_STEPS].dx));
        cor_next[0].ln[1] = cordic_pre($signed({3'b0, sq2_reg[SQ2_STEPS].root[0]}),
                                       34'($signed(sq2_reg[SQ2_STEPS].c[0])));
        cor_next[0].ln[2] = cordic_pre($signed({3'b0, sq2_reg[SQ2_STEPS].root[1]}),
                                       34'($signed(sq2_reg[SQ2_STEPS].c[1])));
        cor_next[0].flag  = sq2_reg[SQ2_STEPS].flag;
        for (int k = 0; k < CORDIC_ITERATIONS; k++) begin
            cor_next[k+1].flag = cor_reg[k].flag;
            for (int j = 0; j < 3; j++) begin
                cor_next[k+1].ln[j] = cordic_step(cor_reg[k].ln[j], 5'(k));
            end
        end
    end

    // Combine angles and round to Q3.20
    always_comb begin
        logic signed [33:0] dir;
        logic signed [33:0] a1;
        logic signed [33:0] a2;
        logic signed [35:0] hip_w;
        logic signed [35:0] knee_w;
        dir = cor_reg[CORDIC_ITERATIONS].ln[0].zero ? 34'sd0 : cor_reg[CORDIC_ITERATIONS].ln[0].z;
        a1  = cor_reg[CORDIC_ITERATIONS].ln[1].zero ? 34'sd0 : cor_reg[CORDIC_ITERATIONS].ln[1].z;
        a2  = cor_reg[CORDIC_ITERATIONS].ln[2].zero ? 34'sd0 : cor_reg[CORDIC_ITERATIONS].ln[2].z;
        hip_w  = 36'(a1) - 36'(dir) + Q20_ROUND;
        knee_w = 36'(a2) - 36'(Q30_PI) + Q20_ROUND;
        out_next.hip_angle   = 24'(hip_w >>> 10);
        out_next.knee_angle  = 24'(knee_w >>> 10);
        out_next.unreachable = cor_reg[CORDIC_ITERATIONS].flag;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            upper_len_reg <= LEN_RESET;
            lower_len_reg <= LEN_RESET;
        end else begin
            upper_len_reg <= upper_len_next;
            lower_len_reg <= lower_len_next;
            if (adv) begin
                vld_reg <= vld_next;
            end
        end
    end

    // Payload registers: advance together, hold on stall
    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg  <= in_next;
            mul_reg <= mul_next;
            sum_reg <= sum_next;
            sq1_reg <= sq1_next;
            pre_reg <= pre_next;
            dv_reg  <= dv_next;
            cs_reg  <= cs_next;
            cq_reg  <= cq_next;
            sq2_reg <= sq2_next;
            cor_reg <= cor_next;
            out_reg <= out_next;
        end
    end

endmodule

/* rtl/core/tlik_checker.sv */
// Port-level assertions for the two-link leg inverse kinematics unit, with its bind.
module tlik_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input tlik_pkg::tlik_out_t m_data,
    input logic                pready
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // Free output side means the input is open
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input blocked while output free");

    // A stalled result blocks new transfers
    a_stall_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    // The configuration port never waits
    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

endmodule

bind two_link_leg_inverse_kinematics_unit tlik_checker u_tlik_checker (.*);
